// ===== hdl/trf_pkg.sv =====
// Shared widths, latencies and types of the triangle rotation frame pipeline.
package trf_pkg;

   localparam int CoordW    = 24;
   localparam int NumCoords = 9;
   localparam int EdgeW     = 25;
   localparam int ProdW     = 2 * EdgeW;
   localparam int WideW     = ProdW + 1;
   localparam int MagW      = 24;
   localparam int PosW      = 6;
   localparam int SqW       = 2 * MagW;
   localparam int SumW      = SqW + 2;
   localparam int RadShift  = 12;
   localparam int RadW      = SumW + RadShift;
   localparam int RootW     = RadW / 2;
   localparam int FracShift = 20;
   localparam int DivSteps  = 15;
   localparam int DvW       = MagW + FracShift + 2;
   localparam int OutW      = 16;

   localparam int SqrtSteps = RadW / 2;
   localparam int CrossLat  = 2;
   localparam int ScaleLat  = 3;
   localparam int UnitLat   = 2 + SqrtSteps + 1 + DivSteps + 1;
   localparam int Latency   = 1 + CrossLat + ScaleLat + CrossLat + ScaleLat + UnitLat;

   // Magnitudes scaled together so that the largest lies in [2^23, 2^24), with signs and an all-zero mark.
   typedef struct packed {
      logic [2:0][MagW-1:0] mag;
      logic [2:0]           neg;
      logic                 zero;
   } scaled_type;

   typedef logic [2:0][OutW-1:0] row_type;

endpackage

// ===== hdl/triangle_rotation_frame_top.sv =====
// Throughput: one triangle per cycle while results are taken; every stage of the pipeline moves together.
// The depth is set mostly by the 31-step square-root and 15-step divide pipelines.
// When the result stage holds an untaken result, the whole pipeline stalls.
// Synchronous reset clears only the valid bits; data registers are not reset.
module triangle_rotation_frame_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 24 bits each from bit 0 up
   input  logic [215:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // r0_x, r0_y, r0_z, r1_x, r1_y, r1_z, r2_x, r2_y, r2_z, 16 bits each from bit 0 up
   output logic [143:0] rsp_tdata,
   // degenerate
   output logic [0:0]   rsp_tuser
);
   import trf_pkg::*;

   localparam int E1Dly   = CrossLat + ScaleLat + CrossLat;
   localparam int RowDly  = CrossLat + ScaleLat;

   logic                   advance;
   logic                   valid_ff [Latency];
   logic [2:0][EdgeW-1:0]  e0_in;
   logic [2:0][EdgeW-1:0]  e1_in;
   logic [2:0][EdgeW-1:0]  e0_ff;
   logic [2:0][EdgeW-1:0]  e1_ff;
   logic [2:0][EdgeW-1:0]  e0_dly_ff [CrossLat];
   logic [2:0][EdgeW-1:0]  e1_dly_ff [E1Dly];
   logic [2:0][WideW-1:0]  nrm;
   logic [2:0][WideW-1:0]  e0_wide;
   scaled_type             es;
   scaled_type             ns;
   logic [2:0][EdgeW-1:0]  es_vec;
   logic [2:0][EdgeW-1:0]  ns_vec;
   logic [2:0][WideW-1:0]  perp;
   logic                   e0z_dly_ff [CrossLat];
   logic [2:0][WideW-1:0]  r1_vec;
   scaled_type             s1;
   row_type                u0;
   row_type                u1;
   row_type                u2;
   row_type                u0_dly_ff [RowDly];
   row_type                u2_dly_ff [RowDly];
   logic                   flag_dly_ff [RowDly];
   logic                   deg_in;
   logic                   deg_dly_ff [UnitLat];

   assign advance    = !valid_ff[Latency-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[Latency-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Latency; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= req_tvalid;
         for (int k = 1; k < Latency; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e0_in[i] = EdgeW'($signed(req_tdata[i*CoordW +: CoordW]))
                  - EdgeW'($signed(req_tdata[(i+6)*CoordW +: CoordW]));
         e1_in[i] = EdgeW'($signed(req_tdata[(i+3)*CoordW +: CoordW]))
                  - EdgeW'($signed(req_tdata[(i+6)*CoordW +: CoordW]));
      end
   end

   trf_cross u_cross_nrm (
      .clock   (clock),
      .advance (advance),
      .p_vec   (e0_ff),
      .q_vec   (e1_ff),
      .r_vec   (nrm)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e0_wide[i] = WideW'($signed(e0_dly_ff[CrossLat-1][i]));
      end
   end

   trf_scale u_scale_e0 (
      .clock   (clock),
      .advance (advance),
      .v_vec   (e0_wide),
      .s_out   (es)
   );

   trf_scale u_scale_nrm (
      .clock   (clock),
      .advance (advance),
      .v_vec   (nrm),
      .s_out   (ns)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         es_vec[i] = es.neg[i] ? (~EdgeW'(es.mag[i]) + 1'b1) : EdgeW'(es.mag[i]);
         ns_vec[i] = ns.neg[i] ? (~EdgeW'(ns.mag[i]) + 1'b1) : EdgeW'(ns.mag[i]);
      end
   end

   // The second row points along cross(normal, first edge), both after scaling.
   trf_cross u_cross_perp (
      .clock   (clock),
      .advance (advance),
      .p_vec   (ns_vec),
      .q_vec   (es_vec),
      .r_vec   (perp)
   );

   // With a zero edge e0 (a - c), row r1 is the edge e1 (b - c) on its own.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r1_vec[i] = e0z_dly_ff[CrossLat-1] ? WideW'($signed(e1_dly_ff[E1Dly-1][i]))
                                            : perp[i];
      end
   end

   trf_scale u_scale_r1 (
      .clock   (clock),
      .advance (advance),
      .v_vec   (r1_vec),
      .s_out   (s1)
   );

   trf_unit u_unit_r0 (
      .clock   (clock),
      .advance (advance),
      .s_in    (es),
      .u_out   (u0)
   );

   trf_unit u_unit_r2 (
      .clock   (clock),
      .advance (advance),
      .s_in    (ns),
      .u_out   (u2)
   );

   trf_unit u_unit_r1 (
      .clock   (clock),
      .advance (advance),
      .s_in    (s1),
      .u_out   (u1)
   );

   assign deg_in = flag_dly_ff[RowDly-1] || s1.zero;

   always_ff @(posedge clock) begin
      if (advance) begin
         e0_ff <= e0_in;
         e1_ff <= e1_in;
         e0_dly_ff[0]  <= e0_ff;
         e1_dly_ff[0]  <= e1_ff;
         e0z_dly_ff[0] <= es.zero;
         u0_dly_ff[0]  <= u0;
         u2_dly_ff[0]  <= u2;
         flag_dly_ff[0] <= es.zero || ns.zero;
         deg_dly_ff[0] <= deg_in;
         for (int k = 1; k < CrossLat; k++) begin
            e0_dly_ff[k]  <= e0_dly_ff[k-1];
            e0z_dly_ff[k] <= e0z_dly_ff[k-1];
         end
         for (int k = 1; k < E1Dly; k++) begin
            e1_dly_ff[k] <= e1_dly_ff[k-1];
         end
         for (int k = 1; k < RowDly; k++) begin
            u0_dly_ff[k]   <= u0_dly_ff[k-1];
            u2_dly_ff[k]   <= u2_dly_ff[k-1];
            flag_dly_ff[k] <= flag_dly_ff[k-1];
         end
         for (int k = 1; k < UnitLat; k++) begin
            deg_dly_ff[k] <= deg_dly_ff[k-1];
         end
      end
   end

   assign rsp_tdata = {u2_dly_ff[RowDly-1], u1, u0_dly_ff[RowDly-1]};
   assign rsp_tuser = deg_dly_ff[UnitLat-1];

endmodule

// ===== hdl/trf_cross.sv =====
// Two-stage pipelined cross product of two signed 3-vectors.
module trf_cross (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [2:0][trf_pkg::EdgeW-1:0] p_vec,
   input  logic [2:0][trf_pkg::EdgeW-1:0] q_vec,
   output logic [2:0][trf_pkg::WideW-1:0] r_vec
);
   import trf_pkg::*;

   logic signed [ProdW-1:0] prod_in [6];
   logic signed [ProdW-1:0] prod_ff [6];
   logic [2:0][WideW-1:0]   r_in;
   logic [2:0][WideW-1:0]   r_ff;

   always_comb begin
      prod_in[0] = $signed(p_vec[1]) * $signed(q_vec[2]);
      prod_in[1] = $signed(p_vec[2]) * $signed(q_vec[1]);
      prod_in[2] = $signed(p_vec[2]) * $signed(q_vec[0]);
      prod_in[3] = $signed(p_vec[0]) * $signed(q_vec[2]);
      prod_in[4] = $signed(p_vec[0]) * $signed(q_vec[1]);
      prod_in[5] = $signed(p_vec[1]) * $signed(q_vec[0]);
      r_in[0] = WideW'(prod_ff[0]) - WideW'(prod_ff[1]);
      r_in[1] = WideW'(prod_ff[2]) - WideW'(prod_ff[3]);
      r_in[2] = WideW'(prod_ff[4]) - WideW'(prod_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 6; k++) begin
            prod_ff[k] <= prod_in[k];
         end
         r_ff <= r_in;
      end
   end

   assign r_vec = r_ff;

endmodule

// ===== hdl/trf_scale.sv =====
// Three-stage block shift that brings the largest magnitude of a vector into [2^23, 2^24).
module trf_scale (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [2:0][trf_pkg::WideW-1:0] v_vec,
   output trf_pkg::scaled_type           s_out
);
   import trf_pkg::*;

   localparam int TopBit = MagW - 1;

   logic [WideW-1:0] mag_in [3];
   logic [WideW-1:0] mag_ff [3];
   logic [2:0]       neg_in;
   logic [2:0]       neg_ff;
   logic [WideW-1:0] mag2_ff [3];
   logic [2:0]       neg2_ff;
   logic [WideW-1:0] or_word;
   logic [PosW-1:0]  pos_in;
   logic [PosW-1:0]  pos_ff;
   logic             zero_in;
   logic             zero_ff;
   logic [WideW-1:0] shifted [3];
   scaled_type       s_in;
   scaled_type       s_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = v_vec[i][WideW-1];
         mag_in[i] = neg_in[i] ? (~v_vec[i] + 1'b1) : v_vec[i];
      end
   end

   // The OR of the magnitudes has the same leading one as their maximum.
   always_comb begin
      or_word = mag_ff[0] | mag_ff[1] | mag_ff[2];
      zero_in = (or_word == '0);
      pos_in  = '0;
      for (int k = 0; k < WideW; k++) begin
         if (or_word[k]) begin
            pos_in = PosW'(k);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pos_ff >= PosW'(TopBit)) begin
            shifted[i] = mag2_ff[i] >> (pos_ff - PosW'(TopBit));
         end else begin
            shifted[i] = mag2_ff[i] << (PosW'(TopBit) - pos_ff);
         end
         s_in.mag[i] = shifted[i][MagW-1:0];
      end
      s_in.neg  = neg2_ff;
      s_in.zero = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i]  <= mag_in[i];
            mag2_ff[i] <= mag_ff[i];
         end
         neg_ff  <= neg_in;
         neg2_ff <= neg_ff;
         pos_ff  <= pos_in;
         zero_ff <= zero_in;
         s_ff    <= s_in;
      end
   end

   assign s_out = s_ff;

endmodule

// ===== hdl/trf_unit.sv =====
// Pipelined normalizer: squares, square-root steps, restoring divide steps and sign.
module trf_unit (
   input  logic                clock,
   input  logic                advance,
   input  trf_pkg::scaled_type s_in,
   output trf_pkg::row_type    u_out
);
   import trf_pkg::*;

   logic [SqW-1:0]   sq_ff [3];
   scaled_type       pay_sq_ff;
   logic [SumW-1:0]  sum;
   logic [RadW-1:0]  x_in [SqrtSteps+1];
   logic [RadW-1:0]  x_ff [SqrtSteps+1];
   logic [RadW-1:0]  r_in [SqrtSteps+1];
   logic [RadW-1:0]  r_ff [SqrtSteps+1];
   logic [RadW-1:0]  trial [SqrtSteps];
   logic [RadW-1:0]  step_bit [SqrtSteps];
   scaled_type       pay_ff [SqrtSteps+1];
   logic [DvW-1:0]   rem_in [DivSteps+1][3];
   logic [DvW-1:0]   rem_ff [DivSteps+1][3];
   logic [DivSteps-1:0] quo_in [DivSteps+1][3];
   logic [DivSteps-1:0] quo_ff [DivSteps+1][3];
   logic [DvW-1:0]   den_ff [DivSteps+1];
   logic [DvW-1:0]   dtrial [DivSteps][3];
   scaled_type       dpay_ff [DivSteps+1];
   logic [RootW-1:0] root;
   logic [OutW-1:0]  qext [3];
   row_type          u_in;
   row_type          u_ff;

   always_comb begin
      sum     = SumW'(sq_ff[0]) + SumW'(sq_ff[1]) + SumW'(sq_ff[2]);
      x_in[0] = {sum, {RadShift{1'b0}}};
      r_in[0] = '0;
      // One result bit of the integer square root per stage.
      for (int k = 0; k < SqrtSteps; k++) begin
         step_bit[k] = RadW'(1) << (2 * (SqrtSteps - 1 - k));
         trial[k]    = r_ff[k] + step_bit[k];
         if (x_ff[k] >= trial[k]) begin
            x_in[k+1] = x_ff[k] - trial[k];
            r_in[k+1] = (r_ff[k] >> 1) + step_bit[k];
         end else begin
            x_in[k+1] = x_ff[k];
            r_in[k+1] = r_ff[k] >> 1;
         end
      end
   end

   // The numerator carries half the divisor so that the quotient rounds to nearest.
   always_comb begin
      root = r_ff[SqrtSteps][RootW-1:0];
      for (int i = 0; i < 3; i++) begin
         rem_in[0][i] = DvW'({pay_ff[SqrtSteps].mag[i], {FracShift{1'b0}}})
                        + DvW'(root >> 1);
         quo_in[0][i] = '0;
      end
      for (int d = 0; d < DivSteps; d++) begin
         for (int i = 0; i < 3; i++) begin
            dtrial[d][i] = den_ff[d] << (DivSteps - 1 - d);
            quo_in[d+1][i] = quo_ff[d][i];
            if (rem_ff[d][i] >= dtrial[d][i]) begin
               rem_in[d+1][i] = rem_ff[d][i] - dtrial[d][i];
               quo_in[d+1][i][DivSteps-1-d] = 1'b1;
            end else begin
               rem_in[d+1][i] = rem_ff[d][i];
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         qext[i] = OutW'(quo_ff[DivSteps][i]);
         if (dpay_ff[DivSteps].zero) begin
            u_in[i] = '0;
         end else if (dpay_ff[DivSteps].neg[i]) begin
            u_in[i] = ~qext[i] + 1'b1;
         end else begin
            u_in[i] = qext[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= s_in.mag[i] * s_in.mag[i];
         end
         pay_sq_ff <= s_in;
         x_ff[0]   <= x_in[0];
         r_ff[0]   <= r_in[0];
         pay_ff[0] <= pay_sq_ff;
         for (int k = 1; k <= SqrtSteps; k++) begin
            x_ff[k]   <= x_in[k];
            r_ff[k]   <= r_in[k];
            pay_ff[k] <= pay_ff[k-1];
         end
         den_ff[0]  <= DvW'(root);
         dpay_ff[0] <= pay_ff[SqrtSteps];
         for (int d = 0; d <= DivSteps; d++) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[d][i] <= rem_in[d][i];
               quo_ff[d][i] <= quo_in[d][i];
            end
         end
         for (int d = 1; d <= DivSteps; d++) begin
            den_ff[d]  <= den_ff[d-1];
            dpay_ff[d] <= dpay_ff[d-1];
         end
         u_ff <= u_in;
      end
   end

   assign u_out = u_ff;

endmodule
